// ===== rtl/sha1bc_pkg.sv =====
// sha1bc_pkg: shared types, constants and round helpers for the sha-1 compression core
// no dependencies; imported by every module in rtl/
package sha1bc_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned IdxW    = 3;
	localparam int unsigned NumH    = 5;
	localparam int unsigned WinDepth = 16;
	localparam int unsigned RoundW  = 7;

	localparam logic [RoundW-1:0] LastRound = 7'd79;
	localparam logic [IdxW-1:0]   LastIdx   = 3'd4;

	// initial chaining value, element 0 is H0
	localparam logic [NumH-1:0][WordW-1:0] IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [WordW-1:0] K0 = 32'h5a827999;
	localparam logic [WordW-1:0] K1 = 32'h6ed9eba1;
	localparam logic [WordW-1:0] K2 = 32'h8f1bbcdc;
	localparam logic [WordW-1:0] K3 = 32'hca62c1d6;

	typedef enum logic [1:0] {
		GRP_CH  = 2'd0,
		GRP_P1  = 2'd1,
		GRP_MAJ = 2'd2,
		GRP_P3  = 2'd3
	} grp_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'd0,
		ST_ROUND = 2'd1,
		ST_ADD   = 2'd2,
		ST_OUT   = 2'd3
	} state_t;

	typedef struct packed {
		logic [WordW-1:0] message_word;
		logic             new_message;
	} msg_t;

	typedef struct packed {
		logic [WordW-1:0] digest_word;
		logic [IdxW-1:0]  digest_index;
		logic             last_word;
	} dig_t;

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] d;
		logic [WordW-1:0] e;
	} vars_t;

	typedef struct packed {
		logic shift_in;
		logic expand;
	} sched_ctrl_t;

	function automatic grp_t round_group(input logic [RoundW-1:0] t);
		grp_t g;
		if (t < 7'd20) g = GRP_CH;
		else if (t < 7'd40) g = GRP_P1;
		else if (t < 7'd60) g = GRP_MAJ;
		else g = GRP_P3;
		return g;
	endfunction

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
		input int unsigned n);
		return (x << n) | (x >> (WordW - n));
	endfunction

endpackage

// ===== rtl/sha1bc_sched.sv =====
// sha1bc_sched: 16-word message schedule window as a shift line with fixed taps
// depends on sha1bc_pkg
module sha1bc_sched import sha1bc_pkg::*; (
	input  logic              clk,
	input  sched_ctrl_t       ctrl,
	input  logic [WordW-1:0]  load_word,
	output logic [WordW-1:0]  w_t
);

	logic [WordW-1:0] win_q [WinDepth];
	logic [WordW-1:0] fresh;

	// window holds W[t..t+15]; the new tail is W[t+16]
	assign fresh = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
	assign w_t   = win_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.shift_in || ctrl.expand) begin
			for (int i = 0; i < WinDepth - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinDepth-1] <= ctrl.shift_in ? load_word : fresh;
		end
	end

endmodule

// ===== rtl/sha1bc_round.sv =====
// sha1bc_round: one sha-1 round, shared by all 80 rounds of a block
// depends on sha1bc_pkg
module sha1bc_round import sha1bc_pkg::*; (
	input  vars_t              cur,
	input  logic [WordW-1:0]   w_t,
	input  logic [RoundW-1:0]  t,
	output vars_t              nxt
);

	grp_t             grp;
	logic [WordW-1:0] f;
	logic [WordW-1:0] k;

	assign grp = round_group(t);

	always_comb begin
		case (grp)
			GRP_CH: begin
				f = (cur.b & cur.c) | (~cur.b & cur.d);
				k = K0;
			end
			GRP_P1: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = K1;
			end
			GRP_MAJ: begin
				f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
				k = K2;
			end
			GRP_P3: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = K3;
			end
			default: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = K3;
			end
		endcase
	end

	always_comb begin
		nxt.a = rotl(cur.a, 5) + f + cur.e + w_t + k;
		nxt.b = cur.a;
		nxt.c = rotl(cur.b, 30);
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

// ===== rtl/sha1_block_compression_core.sv =====
// sha1_block_compression_core: top level, sequencer, chaining value and digest output
// depends on sha1bc_pkg, sha1bc_sched, sha1bc_round
//
// Takes padded 512-bit blocks as sixteen 32-bit big-endian words, one per accepted
// msg word, and after the sixteenth runs the 80 sha-1 rounds through a single round
// unit, one round per clock, then adds the result into the chaining value and sends
// the five digest words H0..H4 on dig, the last one flagged. A block goes through
// loading its sixteen words, the 80 rounds, the add into the chaining value and
// the five output words, which wait while dig is stalled. msg_stall is high from
// the sixteenth word until the last digest word has been taken. new_message reloads
// the initial value and restarts the block at word 0; without it a block chains on
// from the previous digest.
module sha1_block_compression_core import sha1bc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  msg_valid,
	output logic  msg_stall,
	input  msg_t  msg,
	output logic  dig_valid,
	input  logic  dig_stall,
	output dig_t  dig
);

	state_t              state_q, state_nxt;
	logic [3:0]          words_q;
	logic [RoundW-1:0]   round_q;
	logic [IdxW-1:0]     idx_q;
	logic [WordW-1:0]    h_q [NumH];
	vars_t               vars_q;
	vars_t               vars_nxt;
	logic [WordW-1:0]    w_t;
	sched_ctrl_t         sched_ctrl;
	logic                msg_take;
	logic                dig_take;
	logic                block_done;

	assign msg_take   = msg_valid && !msg_stall;
	assign dig_take   = dig_valid && !dig_stall;
	assign block_done = msg_take && !msg.new_message && (words_q == 4'd15);

	sha1bc_sched u_sched (
		.clk       (clk),
		.ctrl      (sched_ctrl),
		.load_word (msg.message_word),
		.w_t       (w_t)
	);

	sha1bc_round u_round (
		.cur (vars_q),
		.w_t (w_t),
		.t   (round_q),
		.nxt (vars_nxt)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD:  if (block_done) state_nxt = ST_ROUND;
			ST_ROUND: if (round_q == LastRound) state_nxt = ST_ADD;
			ST_ADD:   state_nxt = ST_OUT;
			ST_OUT:   if (dig_take && idx_q == LastIdx) state_nxt = ST_LOAD;
			default:  state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		msg_stall           = 1'b1;
		dig_valid           = 1'b0;
		sched_ctrl.shift_in = 1'b0;
		sched_ctrl.expand   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				msg_stall           = 1'b0;
				sched_ctrl.shift_in = msg_valid;
			end
			ST_ROUND: sched_ctrl.expand = 1'b1;
			ST_ADD:   ;
			ST_OUT:   dig_valid = 1'b1;
			default:  ;
		endcase
	end

	always_comb begin
		case (idx_q)
			3'd0:    dig.digest_word = h_q[0];
			3'd1:    dig.digest_word = h_q[1];
			3'd2:    dig.digest_word = h_q[2];
			3'd3:    dig.digest_word = h_q[3];
			default: dig.digest_word = h_q[4];
		endcase
		dig.digest_index = idx_q;
		dig.last_word    = (idx_q == LastIdx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			words_q <= '0;
			round_q <= '0;
			idx_q   <= '0;
			for (int i = 0; i < NumH; i++) begin
				h_q[i] <= IV[i];
			end
		end else begin
			state_q <= state_nxt;
			if (msg_take) begin
				// flagged word restarts the block as word 0
				words_q <= msg.new_message ? 4'd1 : words_q + 4'd1;
				if (msg.new_message) begin
					for (int i = 0; i < NumH; i++) begin
						h_q[i] <= IV[i];
					end
				end
			end
			if (state_q == ST_ROUND) begin
				round_q <= (round_q == LastRound) ? '0 : round_q + 7'd1;
			end
			if (state_q == ST_ADD) begin
				h_q[0] <= h_q[0] + vars_q.a;
				h_q[1] <= h_q[1] + vars_q.b;
				h_q[2] <= h_q[2] + vars_q.c;
				h_q[3] <= h_q[3] + vars_q.d;
				h_q[4] <= h_q[4] + vars_q.e;
				idx_q  <= '0;
			end
			if (dig_take) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (block_done) begin
			vars_q.a <= h_q[0];
			vars_q.b <= h_q[1];
			vars_q.c <= h_q[2];
			vars_q.d <= h_q[3];
			vars_q.e <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_nxt;
		end
	end

`ifndef SYNTHESIS
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= LastRound)
		else $error("round counter past last round");

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("input accepted while digest words pending");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig.last_word |-> dig.digest_index == LastIdx)
		else $error("last flag on wrong digest word");

	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && dig.last_word |=> !msg_stall && !dig_valid)
		else $error("input not reopened after final digest word");

	a_rounds_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && round_q == LastRound |=> state_q == ST_ADD)
		else $error("compression did not end after last round");
`endif

endmodule

// ===== bench/sha1_block_compression_core_tb.sv =====
// sha1_block_compression_core_tb: self-checking bench for the sha-1 block compression core
// depends on rtl/sha1bc_pkg.sv (msg_t, dig_t, grp_t) and rtl/sha1_block_compression_core.sv
// a scoreboard class predicts each digest word; tasks drive message words with random idling
module sha1_block_compression_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1bc_pkg::*;

	localparam int unsigned TotalWords = 500;
	localparam int unsigned QuietWords = 60;
	localparam int unsigned IdleLimit  = 2000;
	localparam int unsigned TailCycles = 20;
	localparam int unsigned MaxReports = 30;

	class digest_scoreboard;
		logic [31:0] chain [5];
		logic [31:0] sched [16];
		int unsigned fill;
		dig_t        digest_q [$];
		int unsigned errors;
		int unsigned reported;

		function new();
			chain[0] = 32'h67452301;
			chain[1] = 32'hEFCDAB89;
			chain[2] = 32'h98BADCFE;
			chain[3] = 32'h10325476;
			chain[4] = 32'hC3D2E1F0;
			for (int i = 0; i < 16; i++) sched[i] = '0;
			fill = 0;
			errors = 0;
			reported = 0;
		endfunction

		function logic [31:0] rol(input logic [31:0] x, input int unsigned n);
			return (x << n) | (x >> (32 - n));
		endfunction

		// 80 rounds over the window, expanding it in place
		function void compress();
			logic [31:0] a, b, c, d, e, f, w, k, tmp;
			grp_t g;
			int unsigned t;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (t = 0; t < 80; t++) begin
				if (t >= 16) begin
					w = sched[(t - 3) % 16] ^ sched[(t - 8) % 16] ^ sched[(t - 14) % 16]
						^ sched[t % 16];
					sched[t % 16] = rol(w, 1);
				end
				w = sched[t % 16];
				g = grp_t'(t / 20);
				case (g)
					GRP_CH: begin
						f = (b & c) | (~b & d);
						k = 32'h5a827999;
					end
					GRP_P1: begin
						f = b ^ c ^ d;
						k = 32'h6ed9eba1;
					end
					GRP_MAJ: begin
						f = (b & c) | (b & d) | (c & d);
						k = 32'h8f1bbcdc;
					end
					default: begin
						f = b ^ c ^ d;
						k = 32'hca62c1d6;
					end
				endcase
				tmp = rol(a, 5) + f + e + w + k;
				e = d;
				d = c;
				c = rol(b, 30);
				b = a;
				a = tmp;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void note_word(input msg_t m);
			dig_t r;
			if (m.new_message) begin
				chain[0] = 32'h67452301;
				chain[1] = 32'hEFCDAB89;
				chain[2] = 32'h98BADCFE;
				chain[3] = 32'h10325476;
				chain[4] = 32'hC3D2E1F0;
				fill = 0;
			end
			sched[fill] = m.message_word;
			fill = (fill + 1) % 16;
			if (fill == 0) begin
				compress();
				for (int i = 0; i < 5; i++) begin
					r.digest_word  = chain[i];
					r.digest_index = 3'(i);
					r.last_word    = (i == 4);
					digest_q.push_back(r);
				end
			end
		endfunction

		function void report(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
			errors++;
			if (reported < MaxReports) begin
				reported++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
			end
		endfunction

		function void check_digest(input dig_t d);
			dig_t e;
			if (digest_q.size() == 0) begin
				errors++;
				if (reported < MaxReports) begin
					reported++;
					$display("%0t: unexpected digest word, expected none, actual %h idx %0d",
						$time, d.digest_word, d.digest_index);
				end
				return;
			end
			e = digest_q.pop_front();
			if (d.digest_word !== e.digest_word)
				report("digest_word", e.digest_word, d.digest_word);
			if (d.digest_index !== e.digest_index)
				report("digest_index", 32'(e.digest_index), 32'(d.digest_index));
			if (d.last_word !== e.last_word)
				report("last_word", 32'(e.last_word), 32'(d.last_word));
		endfunction

		function int unsigned pending();
			return digest_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic msg_valid;
	logic msg_stall;
	msg_t msg;
	logic dig_valid;
	logic dig_stall;
	dig_t dig;

	digest_scoreboard sb;
	bit quiet;
	int unsigned load_pos;
	int unsigned words_sent;
	int unsigned restarts;
	int unsigned words_in;
	int unsigned digests_out;
	int unsigned idle_cycles;

	sha1_block_compression_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (msg_valid && !msg_stall) begin
				sb.note_word(msg);
				words_in++;
			end
			if (dig_valid && !dig_stall) begin
				sb.check_digest(dig);
				digests_out++;
			end
			if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IdleLimit) begin
				$display("%0t: no handshake for %0d cycles", $time, IdleLimit);
				$display("** sha1_block_compression_core: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// digest side stalls in random bursts while not quiet
	initial begin
		dig_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				dig_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				dig_stall <= 1'b0;
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input logic [31:0] w, input logic nm);
		msg       <= '{message_word: w, new_message: nm};
		msg_valid <= 1'b1;
		do @(posedge clk); while (msg_stall);
		@(negedge clk);
		load_pos = nm ? 1 : (load_pos + 1) % 16;
		words_sent++;
		if (nm) restarts++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			msg_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	task automatic send_random();
		logic [31:0] w;
		logic nm;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = 32'h80000000;
			default: w = $urandom();
		endcase
		// mostly whole blocks; a flag in mid-block breaks one now and then
		if (load_pos == 0) nm = ($urandom_range(0, 2) == 0);
		else nm = ($urandom_range(0, 47) == 0);
		send_word(w, nm);
	endtask

	initial begin
		bit paused;
		sb          = new();
		arst_n      = 1'b0;
		msg_valid   = 1'b0;
		msg         = '0;
		quiet       = 1'b0;
		paused      = 1'b0;
		load_pos    = 0;
		words_sent  = 0;
		restarts    = 0;
		words_in    = 0;
		digests_out = 0;
		idle_cycles = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// unflagged block straight after reset chains from the initial value
		for (int i = 0; i < 16; i++) begin
			if (i == 14) send_word(32'h00000001, 1'b0);
			else if (i == 15) send_word(32'h80000000, 1'b0);
			else send_word((i % 2 == 0) ? 32'hFFFFFFFF : 32'h00000000, 1'b0);
		end
		// partial message dropped by a restart in mid-block
		send_word(32'h00000000, 1'b1);
		send_word(32'hFFFFFFFF, 1'b0);
		send_word(32'h55555555, 1'b0);
		send_word(32'hAAAAAAAA, 1'b1);

		while (words_sent < TotalWords) begin
			if (words_sent >= TotalWords - QuietWords) quiet = 1'b1;
			if (!paused && words_sent >= TotalWords / 2 && load_pos == 0) begin
				// hold off until the core has drained every digest word
				paused = 1'b1;
				msg_valid <= 1'b0;
				while (sb.pending() != 0) @(negedge clk);
				@(negedge clk);
			end
			send_random();
		end
		msg_valid <= 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("run covered %0d message words (%0d restarts) and %0d digest words,",
			words_in, restarts, digests_out);
		$display("with random stalls on both sides, a drain pause and a quiet tail");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** sha1_block_compression_core: PASSED **");
		end else begin
			$display("** sha1_block_compression_core: FAILED **");
		end
		$finish;
	end

endmodule
